>>> rtl/lkv_pkg.sv
// Shared types and constants for the LRU key-value cache.
// Used by lkv_tags and lru_key_value_cache; has no dependencies.
package lkv_pkg;

    localparam int DATA_W = 32;
    localparam int CAP_W  = 5;

    typedef enum logic
    {
        FUNC_GET = 1'b0,
        FUNC_SET = 1'b1
    } func_t;

    localparam logic [DATA_W-1:0] MISS_VALUE = '1;

endpackage

>>> rtl/lkv_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lkv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/lkv_tags.sv
// Key registers, valid bits and recency ranks with the parallel key match.
// Depends on lkv_pkg for the data and capacity widths.
module lkv_tags #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [lkv_pkg::DATA_W-1:0]    key,
    input  logic [lkv_pkg::CAP_W-1:0]     capacity,
    input  logic                          commit,
    input  logic                          is_set,
    output logic                          hit,
    output logic [(MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1)-1:0] hit_idx,
    output logic [(MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1)-1:0] wr_idx
);

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    logic [lkv_pkg::DATA_W-1:0] key_reg [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0]     valid_reg, valid_next;
    logic [IW-1:0]              rank_reg [MAX_ENTRIES];
    logic [IW-1:0]              rank_next [MAX_ENTRIES];
    logic [CW-1:0]              count_reg, count_next;

    logic [MAX_ENTRIES-1:0] match;
    logic [MAX_ENTRIES-1:0] evict;
    logic [MAX_ENTRIES-1:0] valid_kept;
    logic [CW-1:0]          eff_cap;
    logic                   need_evict;
    logic [IW-1:0]          slot_idx;
    logic [IW-1:0]          hit_rank;
    logic [IW-1:0]          oldest_rank;

    always_comb
    begin
        if (capacity == '0)
        begin
            eff_cap = CW'(1);
        end
        else if (int'(capacity) > MAX_ENTRIES)
        begin
            eff_cap = CW'(MAX_ENTRIES);
        end
        else
        begin
            eff_cap = CW'(capacity);
        end
    end

    assign need_evict  = (count_reg >= eff_cap);
    assign oldest_rank = IW'(count_reg - CW'(1));

    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--)
        begin
            match[i] = valid_reg[i] && (key_reg[i] == key);
            evict[i] = need_evict && valid_reg[i] && (rank_reg[i] == oldest_rank);
            if (match[i])
            begin
                hit     = 1'b1;
                hit_idx = IW'(i);
            end
        end
        valid_kept = valid_reg & ~evict;
        slot_idx   = '0;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_kept[i])
            begin
                slot_idx = IW'(i);
            end
        end
        wr_idx   = hit ? hit_idx : slot_idx;
        hit_rank = rank_reg[hit_idx];
    end

    // A hit ages only the entries more recent than it; an insertion ages all survivors.
    always_comb
    begin
        valid_next = valid_reg;
        count_next = count_reg;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            rank_next[i] = rank_reg[i];
        end
        if (hit)
        begin
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                if (valid_reg[i] && rank_reg[i] < hit_rank)
                begin
                    rank_next[i] = rank_reg[i] + IW'(1);
                end
            end
            rank_next[hit_idx] = '0;
        end
        else if (is_set)
        begin
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                if (evict[i])
                begin
                    rank_next[i] = '0;
                end
                else if (valid_reg[i])
                begin
                    rank_next[i] = rank_reg[i] + IW'(1);
                end
            end
            valid_next           = valid_kept;
            valid_next[slot_idx] = 1'b1;
            rank_next[slot_idx]  = '0;
            count_next = count_reg + CW'(1) - (need_evict ? CW'(1) : CW'(0));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else if (commit)
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit && !hit && is_set)
        begin
            key_reg[slot_idx] <= key;
        end
    end

    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) == $countones(valid_reg))
        else $error("entry count differs from the number of valid entries");

    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match))
        else $error("key present in more than one entry");

    a_insert_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && !hit && is_set) |-> !valid_kept[slot_idx])
        else $error("insertion found no free entry");

endmodule

>>> rtl/lru_key_value_cache.sv
// LRU key-value cache top level. An accepted request is registered, its key matched in
// lkv_tags in S_LOOK, and for a get hit the value memory read in S_READ; the result then
// is loaded into the output register once it is free; only then is a new request taken.
// A finished result waits in an output register while the next request is taken.
// Reset clears all valid bits, ranks and the count at once and sets capacity to 16.
// Depends on lkv_pkg, lkv_tags and lkv_ram.
module lru_key_value_cache #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lkv_pkg::CAP_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          func,
    input  logic signed [lkv_pkg::DATA_W-1:0] lookup_key,
    input  logic signed [lkv_pkg::DATA_W-1:0] write_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          found,
    output logic signed [lkv_pkg::DATA_W-1:0] read_value
);

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_LOOK,
        S_READ
    } state_t;

    state_t                        state_reg;
    logic [lkv_pkg::CAP_W-1:0]     capacity_reg;
    lkv_pkg::func_t                func_reg;
    logic [lkv_pkg::DATA_W-1:0]    key_reg;
    logic [lkv_pkg::DATA_W-1:0]    value_reg;
    logic                          out_valid_reg;
    logic                          found_reg;
    logic [lkv_pkg::DATA_W-1:0]    read_value_reg;

    logic                          hit;
    logic [IW-1:0]                 hit_idx;
    logic [IW-1:0]                 wr_idx;
    logic                          out_free;
    logic                          commit;
    logic                          is_set;
    logic                          ram_we;
    logic                          ram_re;
    logic                          result_load;
    logic [lkv_pkg::DATA_W-1:0]    ram_rdata;

    assign cfg_ready  = 1'b1;
    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign found      = found_reg;
    assign read_value = read_value_reg;

    assign out_free = !out_valid_reg || out_ready;
    assign is_set   = (func_reg == lkv_pkg::FUNC_SET);
    // A get hit commits and starts the value read at once; others wait for a free output slot.
    assign ram_re   = (state_reg == S_LOOK) && hit && !is_set;
    assign commit   = ram_re || ((state_reg == S_LOOK) && out_free);
    assign ram_we   = (state_reg == S_LOOK) && out_free && is_set;
    assign result_load = ((state_reg == S_LOOK) && !ram_re && out_free)
                      || ((state_reg == S_READ) && out_free);

    lkv_tags #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_tags (
        .clk      (clk),
        .rst_n    (rst_n),
        .key      (key_reg),
        .capacity (capacity_reg),
        .commit   (commit),
        .is_set   (is_set),
        .hit      (hit),
        .hit_idx  (hit_idx),
        .wr_idx   (wr_idx)
    );

    lkv_ram #(
        .WIDTH(lkv_pkg::DATA_W),
        .DEPTH(MAX_ENTRIES)
    ) u_values (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_idx),
        .wdata (value_reg),
        .re    (ram_re),
        .raddr (hit_idx),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            capacity_reg   <= lkv_pkg::CAP_W'(16);
            out_valid_reg  <= 1'b0;
            found_reg      <= 1'b0;
            read_value_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                capacity_reg <= cfg_data;
            end
            if (result_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_LOOK;
                    end
                end
                S_LOOK:
                begin
                    if (ram_re)
                    begin
                        state_reg <= S_READ;
                    end
                    else if (out_free)
                    begin
                        found_reg      <= hit;
                        read_value_reg <= is_set ? value_reg : lkv_pkg::MISS_VALUE;
                        state_reg      <= S_IDLE;
                    end
                end
                S_READ:
                begin
                    if (out_free)
                    begin
                        found_reg      <= 1'b1;
                        read_value_reg <= ram_rdata;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            func_reg  <= lkv_pkg::func_t'(func);
            key_reg   <= lookup_key;
            value_reg <= write_value;
        end
    end

    a_read_follows_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ && !$past(state_reg == S_READ)) |-> $past(ram_re))
        else $error("value read state entered without a get hit");

    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> $stable(read_value_reg))
        else $error("pending result overwritten");

    a_commit_once: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> (state_reg != S_LOOK))
        else $error("request committed while lookup state persists");

endmodule
